// File: rtl/fpp_pkg.sv
// Package for the fixed-partition placement block.
// Holds the beat structs, the command, policy and register codes, and the
// control and record types that pass between the top level and its cells.
package fpp_pkg;

    localparam int AMOUNT_W  = 16;
    localparam int SLOT_W    = 4;
    localparam int SUM_W     = 20;
    localparam int CMD_W     = 2;
    localparam int POLICY_W  = 2;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    // Widest slot number that the supported table depths need.
    localparam int SLOT_ID_W = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b1;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 5'd16;
    localparam logic [SUM_W-1:0] SUM_MAX            = '1;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic                placed;
        logic [SLOT_W-1:0]   chosen_slot;
        logic [AMOUNT_W-1:0] granted_size;
        logic [AMOUNT_W-1:0] waste;
        logic [SUM_W-1:0]    total_waste;
    } rsp_t;

    typedef struct packed {
        logic [POLICY_W-1:0]  policy;
        logic [SLOT_ID_W:0]   n;
        logic [SLOT_ID_W-1:0] pos;
        logic [AMOUNT_W-1:0]  amount;
        logic                 load;
        logic                 take;
        logic                 restart;
        logic [SLOT_ID_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic                 valid;
        logic                 upper;
        logic [SLOT_ID_W-1:0] slot;
        logic [AMOUNT_W-1:0]  size;
    } rec_t;

endpackage

// File: rtl/fixed_partition_placement.sv
// Fixed-partition placement block: top level with the command sequencer and
// the chain of partition cells. Depends on fpp_pkg and fpp_cell.
//
// Usage: commands arrive as req beats (valid/ready) and every command yields
// one rsp beat (valid/ready). A load writes one slot's size and frees it, an
// allocate places a request under the policy register, a restart frees every
// slot and clears the waste total and the next-fit pointer. The policy and
// the number of slots in use are to be set by the user through the cfg write
// port while idle; the block itself does not enforce this. An allocate is
// accepted in idle, scans while the candidate record moves one cell along the
// chain each cycle, then responds; load, restart and unknown commands go from
// idle straight to the response state. One command is in work at a time.
// A finished beat waits in the output register while the next command is
// taken and scanned; if the receiver still stalls, the block holds that next
// result back and the table is not changed until the beat can be sent.
// Reset clears every slot to size zero and not free, the waste total and the
// next-fit pointer, and sets the policy to first fit and the slots in use to 16.
module fixed_partition_placement
    import fpp_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int SIZE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IW     = $clog2(SLOTS);
    localparam int SIZE_W = (SIZE_BITS < AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
    localparam int NW     = SLOT_ID_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    req_t                cmd_reg;
    req_t                cmd_next;
    logic [IW-1:0]       cnt_reg;
    logic [IW-1:0]       cnt_next;
    logic [IW-1:0]       rover_reg;
    logic [IW-1:0]       rover_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [POLICY_W-1:0] policy_reg;
    logic [CFG_W-1:0]    siu_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    rec_t                chain [0:SLOTS];
    rec_t                fin;
    ctl_t                ctl;
    logic [NW-1:0]       n;
    logic                fire;
    logic                is_alloc;
    logic [AMOUNT_W-1:0] waste_now;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_placed;

    assign chain[0] = '0;
    assign fin      = chain[SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        fpp_cell #(
            .INDEX  (i),
            .SIZE_W (SIZE_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .rec_in  (chain[i]),
            .rec_out (chain[i+1])
        );
    end

    always_comb
    begin
        n = (NW'(siu_reg) > NW'(SLOTS)) ? NW'(SLOTS) : NW'(siu_reg);
        fire      = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp_ready);
        is_alloc  = cmd_reg.command == CMD_ALLOC;
        waste_now = fin.size - cmd_reg.amount;
        sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(waste_now);
        sum_placed = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

        ctl.policy  = policy_reg;
        ctl.n       = n;
        ctl.pos     = (NW'(rover_reg) < n) ? SLOT_ID_W'(rover_reg) : '0;
        ctl.amount  = cmd_reg.amount;
        ctl.load    = fire && (cmd_reg.command == CMD_LOAD);
        ctl.take    = fire && is_alloc && fin.valid;
        ctl.restart = fire && (cmd_reg.command == CMD_RESTART);
        ctl.target  = (cmd_reg.command == CMD_LOAD) ? SLOT_ID_W'(cmd_reg.slot) : fin.slot;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        rover_next     = rover_reg;
        sum_next       = sum_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = req;
                    cmd_next.amount = AMOUNT_W'(req.amount[SIZE_W-1:0]);
                    cnt_next        = '0;
                    state_next      = (req.command == CMD_ALLOC) ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(SLOTS - 1))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (fire)
                begin
                    rsp_next       = '0;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (ctl.take)
                    begin
                        rsp_next.placed       = 1'b1;
                        rsp_next.chosen_slot  = fin.slot[SLOT_W-1:0];
                        rsp_next.granted_size = fin.size;
                        rsp_next.waste        = waste_now;
                        rover_next            = fin.slot[IW-1:0];
                        sum_next              = sum_placed;
                    end
                    if (ctl.restart)
                    begin
                        rover_next = '0;
                        sum_next   = '0;
                    end
                    rsp_next.total_waste = sum_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rover_reg     <= '0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rover_reg     <= rover_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            siu_reg    <= SLOTS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY:       policy_reg <= cfg_data[POLICY_W-1:0];
                REG_SLOTS_IN_USE: siu_reg    <= cfg_data;
                default:          policy_reg <= policy_reg;
            endcase
        end
    end

    assign req_ready = state_reg == ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cnt_reg == IW'(SLOTS - 1)) |=> state_reg == ST_RESP)
        else $error("scan did not end after the last cell");

    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> (fin.size >= cmd_reg.amount && NW'(fin.slot) < n))
        else $error("granted partition does not fit the request");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("a second command was taken while one is in work");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.restart |=> (rsp_valid_reg && !rsp_reg.placed && rsp_reg.total_waste == '0
                         && rover_reg == '0))
        else $error("restart did not clear the waste total");

endmodule

// File: rtl/fpp_cell.sv
// One partition cell: holds one slot's size and free mark and passes the
// running placement candidate on to its neighbour every cycle.
// Depends on fpp_pkg.
module fpp_cell
    import fpp_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int SIZE_W = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  ctl_t ctl,
    input  rec_t rec_in,
    output rec_t rec_out
);

    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   size_next;
    logic                free_reg;
    logic                free_next;
    rec_t                rec_reg;
    rec_t                rec_next;
    logic [AMOUNT_W-1:0] size_ext;
    logic                fits;
    logic                upper;
    logic                better;
    logic                take_here;
    logic                hit;

    always_comb
    begin
        size_ext  = AMOUNT_W'(size_reg);
        upper     = SLOT_ID_W'(INDEX) >= ctl.pos;
        fits      = ((SLOT_ID_W + 1)'(INDEX) < ctl.n) && free_reg && (size_ext >= ctl.amount);
        case (ctl.policy)
            POL_BEST:  better = size_ext < rec_in.size;
            POL_WORST: better = size_ext > rec_in.size;
            POL_NEXT:  better = upper && !rec_in.upper;
            default:   better = 1'b0;
        endcase
        take_here = fits && (!rec_in.valid || better);
        rec_next  = rec_in;
        if (take_here)
        begin
            rec_next.valid = 1'b1;
            rec_next.upper = upper;
            rec_next.slot  = SLOT_ID_W'(INDEX);
            rec_next.size  = size_ext;
        end
    end

    always_comb
    begin
        hit       = ctl.target == SLOT_ID_W'(INDEX);
        size_next = size_reg;
        free_next = free_reg;
        if (ctl.restart)
        begin
            free_next = 1'b1;
        end
        if (ctl.load && hit)
        begin
            size_next = ctl.amount[SIZE_W-1:0];
            free_next = 1'b1;
        end
        if (ctl.take && hit)
        begin
            free_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            free_reg <= 1'b0;
            rec_reg  <= '0;
        end
        else
        begin
            size_reg <= size_next;
            free_reg <= free_next;
            rec_reg  <= rec_next;
        end
    end

    assign rec_out = rec_reg;

    a_take_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.take && hit) |-> free_reg)
        else $error("a partition that is not free was taken");

endmodule
